@@ rtl/svt_pkg.sv @@
// Package for the sensor voltage to temperature converter: field widths,
// the descending voltage table, the per-segment slope table and payload widths.
// Depends on nothing; every other file of the block uses it.
package svt_pkg;

	// Field widths of the two channels.
	localparam int unsigned ADC_W  = 24;
	localparam int unsigned TEMP_W = 16;

	// The ADC code is the low part of the received word.
	localparam int unsigned CODE_W     = 17;
	localparam int unsigned CODE_SCALE = 125;

	// Voltage in eighths of a microvolt, and table entries scaled to match.
	localparam int unsigned VOLT_W      = 24;
	localparam int unsigned ENTRY_UV_W  = 21;
	localparam int unsigned ENTRY_SHIFT = 3;

	localparam int unsigned TABLE_ENTRIES = 21;
	localparam int unsigned IDX_W         = 5;

	// Difference below an entry, slope, divisor, dividend and quotient widths.
	localparam int unsigned DIFF_W  = 22;
	localparam int unsigned SLOPE_W = 13;
	localparam int unsigned DIV_W   = SLOPE_W + 1;
	localparam int unsigned N_W     = 26;
	localparam int unsigned Q_W     = 13;
	localparam int unsigned DIFF_MUL = 25;

	// Ten degrees per table step and minus fifty degrees at the first entry.
	localparam int unsigned STEP_CENTI = 1000;
	localparam int unsigned BASE_CENTI = 5000;
	localparam int          TEMP_MIN   = -5000;
	localparam int          TEMP_MAX   = 20467;

	// Sensor output voltage in microvolts, from -50 C upwards in 10 C steps.
	localparam logic [ENTRY_UV_W-1:0] VOLT_UV [TABLE_ENTRIES] = '{
		21'd1350441, 21'd1300593, 21'd1250398, 21'd1199884, 21'd1149070,
		21'd1097987, 21'd1046647, 21'd995050,  21'd943227,  21'd891178,
		21'd838882,  21'd786360,  21'd733608,  21'd680654,  21'd627490,
		21'd574117,  21'd520551,  21'd466760,  21'd412739,  21'd358164,
		21'd302785
	};

	// Segment slope in thousandths of a millivolt per degree.
	localparam logic [SLOPE_W-1:0] SLOPE_MILLI [TABLE_ENTRIES] = '{
		13'd4985, 13'd5020, 13'd5051, 13'd5081, 13'd5108,
		13'd5134, 13'd5160, 13'd5182, 13'd5205, 13'd5230,
		13'd5252, 13'd5275, 13'd5295, 13'd5316, 13'd5337,
		13'd5357, 13'd5379, 13'd5402, 13'd5458, 13'd5538,
		13'd5538
	};

endpackage

@@ rtl/svt_ifs.sv @@
// Handshake interfaces for the converter's sample and result channels.
// Depends on svt_pkg for the payload widths.
interface svt_sample_if;
	logic                      valid;
	logic                      ready;
	logic [svt_pkg::ADC_W-1:0] adc_raw;

	modport source (output valid, output adc_raw, input ready);
	modport sink (input valid, input adc_raw, output ready);
endinterface

interface svt_result_if;
	logic                              valid;
	logic                              ready;
	logic signed [svt_pkg::TEMP_W-1:0] temp_centi;
	logic                              in_range;

	modport source (output valid, output temp_centi, output in_range, input ready);
	modport sink (input valid, input temp_centi, input in_range, output ready);
endinterface

@@ rtl/sensor_voltage_to_temperature.sv @@
// Top level of the sensor voltage to temperature converter: an 18-stage pipeline
// with a table search, a segment select and a pipelined restoring divider.
// Depends on svt_pkg and the interfaces in svt_ifs.sv.
//
//  channel  | direction | payload                          | handshake
//  ---------+-----------+----------------------------------+--------------
//  sample   | in        | adc_raw[23:0]                    | valid / ready
//  result   | out       | temp_centi[15:0] s, in_range     | valid / ready
//
// One transaction is accepted in every cycle while the pipeline is not frozen.
// The eighteen register stages come from the thirteen quotient bits of the
// divider, one compare-and-subtract stage per bit, plus five other stages.
// Reset clears only the valid bits of the stages; the data registers are left.
// When a result is waiting and result.ready is low the whole pipeline freezes
// and sample.ready drops, so no transaction is lost or repeated.
module sensor_voltage_to_temperature (
	input logic        clk,
	input logic        arst_n,
	svt_sample_if.sink   sample,
	svt_result_if.source result
);
	import svt_pkg::*;

	// The pipeline moves as one whenever the output register is free or being read.
	logic adv;

	// Stage 1: mask the ADC word to its code and scale it to eighths of a microvolt.
	logic              vld_s1;
	logic [VOLT_W-1:0] v_s1;

	// Stage 2: table search result.
	logic              vld_s2;
	logic [VOLT_W-1:0] v_s2;
	logic [IDX_W-1:0]  idx_s2;
	logic              rng_s2;
	logic [IDX_W-1:0]  idx_c;
	logic              hit_c;

	// Stage 3: distance below the selected entry and the segment slope.
	logic               vld_s3;
	logic [IDX_W-1:0]   idx_s3;
	logic               rng_s3;
	logic [DIFF_W-1:0]  d_s3;
	logic [SLOPE_W-1:0] slope_s3;
	logic [IDX_W-1:0]   sel_c;
	logic [VOLT_W-1:0]  entry_c;

	// Stage 4: dividend 25*d + s and divisor 2*s, so that the quotient is the
	// rounded temperature offset with halves rounded up.
	logic             vld_s4;
	logic [IDX_W-1:0] idx_s4;
	logic             rng_s4;
	logic [N_W-1:0]   n_s4;
	logic [DIV_W-1:0] div_s4;

	// Stages 5 to 17: one quotient bit per stage, most significant first.
	logic             vld_s [Q_W];
	logic [IDX_W-1:0] idx_s [Q_W];
	logic             rng_s [Q_W];
	logic [N_W-1:0]   rem_s [Q_W];
	logic [Q_W-1:0]   q_s   [Q_W];
	logic [DIV_W-1:0] div_s [Q_W];

	// Stage 18: the output register.
	logic              vld_s18;
	logic [TEMP_W-1:0] temp_s18;
	logic              rng_s18;
	logic [TEMP_W-1:0] temp_c;

	assign adv          = !vld_s18 || result.ready;
	assign sample.ready = adv;

	// ---------------------------------------------------------------- stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			v_s1 <= VOLT_W'(sample.adc_raw[CODE_W-1:0]) * VOLT_W'(CODE_SCALE);
		end
	end

	// ---------------------------------------------------------------- stage 2
	// The table descends, so the entries at or above the voltage form a prefix;
	// the last of them is the segment. None at all means the voltage is above
	// the top entry and the sample is out of range.
	always_comb begin
		idx_c = '0;
		hit_c = 1'b0;
		for (int k = 0; k < TABLE_ENTRIES; k++) begin
			if ({VOLT_UV[k], ENTRY_SHIFT'(0)} >= v_s1) begin
				idx_c = IDX_W'(k);
				hit_c = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			v_s2   <= v_s1;
			idx_s2 <= idx_c;
			rng_s2 <= hit_c;
		end
	end

	// ---------------------------------------------------------------- stage 3
	// Below the last entry the last segment is extrapolated, so the difference
	// can reach the whole last entry. Out of range the difference is
	// meaningless and the result is forced to zero at the end.
	assign sel_c   = (idx_s2 < IDX_W'(TABLE_ENTRIES)) ? idx_s2 : '0;
	assign entry_c = {VOLT_UV[sel_c], ENTRY_SHIFT'(0)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (adv) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s3   <= idx_s2;
			rng_s3   <= rng_s2;
			d_s3     <= DIFF_W'(entry_c - v_s2);
			slope_s3 <= SLOPE_MILLI[sel_c];
		end
	end

	// ---------------------------------------------------------------- stage 4
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (adv) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			idx_s4 <= idx_s3;
			rng_s4 <= rng_s3;
			n_s4   <= N_W'(d_s3) * N_W'(DIFF_MUL) + N_W'(slope_s3);
			div_s4 <= {slope_s3, 1'b0};
		end
	end

	// ----------------------------------------------------------- stages 5..17
	// Restoring division. The dividend is below 2^26 and the divisor at least
	// 9970, so thirteen quotient bits always suffice.
	for (genvar j = 0; j < Q_W; j++) begin : g_div
		localparam int unsigned SH = Q_W - 1 - j;

		logic             vld_in;
		logic [IDX_W-1:0] idx_in;
		logic             rng_in;
		logic [N_W-1:0]   rem_in;
		logic [Q_W-1:0]   q_in;
		logic [DIV_W-1:0] div_in;
		logic [N_W:0]     den_sh;
		logic [N_W:0]     trial;

		if (j == 0) begin : g_first
			assign vld_in = vld_s4;
			assign idx_in = idx_s4;
			assign rng_in = rng_s4;
			assign rem_in = n_s4;
			assign q_in   = '0;
			assign div_in = div_s4;
		end else begin : g_next
			assign vld_in = vld_s[j-1];
			assign idx_in = idx_s[j-1];
			assign rng_in = rng_s[j-1];
			assign rem_in = rem_s[j-1];
			assign q_in   = q_s[j-1];
			assign div_in = div_s[j-1];
		end

		assign den_sh = (N_W + 1)'(div_in) << SH;
		assign trial  = {1'b0, rem_in} - den_sh;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j] <= 1'b0;
			end else if (adv) begin
				vld_s[j] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				idx_s[j] <= idx_in;
				rng_s[j] <= rng_in;
				div_s[j] <= div_in;
				q_s[j]   <= {q_in[Q_W-2:0], !trial[N_W]};
				rem_s[j] <= trial[N_W] ? rem_in : trial[N_W-1:0];
			end
		end
	end

	// ---------------------------------------------------------------- stage 18
	// Ten degrees per segment from minus fifty, plus the rounded offset. The
	// sum wraps in sixteen bits, which is exact for every reachable value.
	assign temp_c = TEMP_W'(idx_s[Q_W-1]) * TEMP_W'(STEP_CENTI)
		- TEMP_W'(BASE_CENTI) + TEMP_W'(q_s[Q_W-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s18 <= 1'b0;
		end else if (adv) begin
			vld_s18 <= vld_s[Q_W-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rng_s18  <= rng_s[Q_W-1];
			temp_s18 <= rng_s[Q_W-1] ? temp_c : '0;
		end
	end

	assign result.valid      = vld_s18;
	assign result.temp_centi = temp_s18;
	assign result.in_range   = rng_s18;

	// ---------------------------------------------------------------- checks
	a_out_of_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.in_range |-> result.temp_centi == '0)
		else $error("out-of-range result carries a non-zero temperature");

	a_temp_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.in_range |->
			$signed(result.temp_centi) >= TEMP_W'(TEMP_MIN) &&
			$signed(result.temp_centi) <= TEMP_W'(TEMP_MAX))
		else $error("temperature outside the span of the table");

	a_index_valid: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 |-> idx_s2 < IDX_W'(TABLE_ENTRIES))
		else $error("table search produced an index beyond the table");

	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[Q_W-1] |-> rem_s[Q_W-1] < N_W'(div_s[Q_W-1]))
		else $error("divider remainder not below the divisor");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[Q_W-1] && !adv |=> $stable(q_s[Q_W-1]) && vld_s[Q_W-1])
		else $error("divider output changed while the pipeline was stalled");

endmodule

@@ verif/svt_reading_checker.sv @@
`timescale 1ns / 1ps
// Checker for the sensor voltage to temperature converter: watches both channels,
// predicts each reading and compares it with the result transaction.
// Depends on svt_pkg and the interfaces in svt_ifs.sv.
module svt_reading_checker (
	input logic   clk,
	input logic   arst_n,
	svt_sample_if sample_ch,
	svt_result_if result_ch,
	output int    failures,
	output int    outstanding
);
	import svt_pkg::*;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temp_centi;
		logic                     in_range;
	} reading_t;

	localparam int SEGMENTS = 21;

	// Sensor voltage in microvolts at -50 C and every 10 C above it.
	localparam logic [20:0] SENSE_UV [SEGMENTS] = '{
		21'd1350441, 21'd1300593, 21'd1250398, 21'd1199884, 21'd1149070,
		21'd1097987, 21'd1046647, 21'd995050,  21'd943227,  21'd891178,
		21'd838882,  21'd786360,  21'd733608,  21'd680654,  21'd627490,
		21'd574117,  21'd520551,  21'd466760,  21'd412739,  21'd358164,
		21'd302785
	};

	// Segment slope in microvolts per degree.
	localparam logic [12:0] SEG_SLOPE [SEGMENTS] = '{
		13'd4985, 13'd5020, 13'd5051, 13'd5081, 13'd5108,
		13'd5134, 13'd5160, 13'd5182, 13'd5205, 13'd5230,
		13'd5252, 13'd5275, 13'd5295, 13'd5316, 13'd5337,
		13'd5357, 13'd5379, 13'd5402, 13'd5458, 13'd5538,
		13'd5538
	};

	reading_t readings_due [$];
	reading_t got;
	reading_t want;
	logic     wrong;

	// The voltage is held in eighths of a microvolt so the table can be compared
	// after a shift, and the quotient rounds halves upwards.
	function automatic reading_t convert_sample(logic [ADC_W-1:0] raw);
		logic [23:0] volt_e8;
		logic [23:0] level_e8;
		logic [31:0] gap_scaled;
		logic [31:0] steps;
		int          seg;
		reading_t    r;
		volt_e8 = 24'(raw[16:0]) * 24'd125;
		seg = -1;
		for (int k = 0; k < SEGMENTS; k++)
			if ({SENSE_UV[k], 3'b000} >= volt_e8)
				seg = k;
		if (seg < 0) begin
			r.temp_centi = '0;
			r.in_range   = 1'b0;
			return r;
		end
		level_e8   = {SENSE_UV[seg], 3'b000};
		gap_scaled = 32'(level_e8 - volt_e8) * 32'd25 + 32'(SEG_SLOPE[seg]);
		steps      = gap_scaled / (32'(SEG_SLOPE[seg]) * 32'd2);
		r.temp_centi = 16'(seg * 1000 - 5000 + int'(steps));
		r.in_range   = 1'b1;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			readings_due.delete();
			failures    <= 0;
			outstanding <= 0;
		end else begin
			// The result side is handled first so that a stray result is never
			// paired with a sample accepted in the same cycle.
			if (result_ch.valid && result_ch.ready) begin
				got.temp_centi = result_ch.temp_centi;
				got.in_range   = result_ch.in_range;
				if (readings_due.size() == 0) begin
					$display("%0t: result with nothing expected, got temp %0d in_range %0b",
						$time, got.temp_centi, got.in_range);
					failures <= failures + 1;
				end else begin
					want  = readings_due.pop_front();
					wrong = 1'b0;
					if (got.temp_centi !== want.temp_centi) begin
						$display("%0t: temp_centi mismatch, expected %0d, actual %0d",
							$time, want.temp_centi, got.temp_centi);
						wrong = 1'b1;
					end
					if (got.in_range !== want.in_range) begin
						$display("%0t: in_range mismatch, expected %0b, actual %0b",
							$time, want.in_range, got.in_range);
						wrong = 1'b1;
					end
					if (wrong)
						failures <= failures + 1;
				end
			end
			if (sample_ch.valid && sample_ch.ready)
				readings_due.push_back(convert_sample(sample_ch.adc_raw));
			outstanding <= readings_due.size();
		end
	end

endmodule

@@ verif/sensor_voltage_to_temperature_test.sv @@
`timescale 1ns / 1ps
// Top of the converter's testbench: clock, reset, sample stimulus and result
// back-pressure, with svt_reading_checker doing the prediction and comparison.
// Depends on svt_pkg, svt_ifs.sv, the converter and svt_reading_checker.
module sensor_voltage_to_temperature_test;
	import svt_pkg::*;

	localparam int RANDOM_SAMPLES = 400;
	localparam int DRAIN_CYCLES   = 40;

	// Codes that put the voltage inside the table span: the top entry is met
	// up to 86428, and 19378 is the last code still below the bottom entry.
	localparam int CODE_TOP_IN  = 86428;
	localparam int CODE_LOW_IN  = 19379;
	localparam int CODE_MAX     = 131071;

	logic clk;
	logic arst_n;
	logic calm;
	int   failures;
	int   outstanding;

	svt_sample_if sample_ch ();
	svt_result_if result_ch ();

	sensor_voltage_to_temperature uut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch)
	);

	svt_reading_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.sample_ch   (sample_ch),
		.result_ch   (result_ch),
		.failures    (failures),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// The run is cut short here if the handshakes ever stop moving.
	initial begin
		#400000;
		$display("== FAIL ==");
		$finish;
	end

	// The receiver stalls in about a third of the cycles, except while the
	// stimulus asks for a calm stretch in which it always takes results.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= calm || ($urandom_range(0, 99) >= 34);
		end
	end

	// The ADC code which gives the voltage nearest at or below a table entry.
	function automatic int entry_code(int k);
		return (int'(VOLT_UV[k]) * 8) / 125;
	endfunction

	// Random words lean on the table span and on the codes around each entry,
	// with a share above the top entry, below the bottom one, and unconstrained.
	function automatic logic [ADC_W-1:0] random_word();
		int          pick;
		logic [16:0] code;
		pick = $urandom_range(0, 99);
		if (pick < 50)
			code = 17'($urandom_range(CODE_LOW_IN, CODE_TOP_IN));
		else if (pick < 75)
			code = 17'(entry_code($urandom_range(0, TABLE_ENTRIES - 1))
				+ int'($urandom_range(0, 3)) - 1);
		else if (pick < 85)
			code = 17'($urandom_range(CODE_TOP_IN + 1, CODE_MAX));
		else if (pick < 95)
			code = 17'($urandom_range(0, CODE_LOW_IN - 1));
		else
			return 24'($urandom);
		// The upper seven bits are ignored by the block but still toggled here.
		return {7'($urandom), code};
	endfunction

	// Presents one sample and holds it until the transaction completes.
	task automatic send_sample(logic [ADC_W-1:0] word);
		sample_ch.valid   <= 1'b1;
		sample_ch.adc_raw <= word;
		do @(posedge clk); while (!sample_ch.ready);
	endtask

	// After a transaction each following cycle is left idle with a chance of
	// about a third, so the sender idles in about a third of all cycles.
	task automatic maybe_idle();
		while (!calm && $urandom_range(0, 99) < 34) begin
			sample_ch.valid   <= 1'b0;
			sample_ch.adc_raw <= 24'($urandom);
			@(posedge clk);
		end
	endtask

	// Holds the sender back until every reading in flight has come out.
	task automatic wait_for_drain();
		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	initial begin
		logic [ADC_W-1:0] corner_words [$];
		arst_n            = 1'b0;
		calm              = 1'b0;
		sample_ch.valid   = 1'b0;
		sample_ch.adc_raw = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words: all-zero and all-one fields, codes either side of the
		// top and bottom entries and of a few inner ones, and ignored upper bits.
		corner_words.push_back(24'h000000);
		corner_words.push_back(24'hFFFFFF);
		corner_words.push_back(24'h01FFFF);
		corner_words.push_back(24'hFE0000);
		corner_words.push_back(24'h000001);
		corner_words.push_back(24'(entry_code(0)));
		corner_words.push_back(24'(entry_code(0) + 1));
		corner_words.push_back(24'h7F0000 | 24'(entry_code(0)));
		corner_words.push_back(24'(entry_code(TABLE_ENTRIES - 1)));
		corner_words.push_back(24'(entry_code(TABLE_ENTRIES - 1) + 1));
		corner_words.push_back(24'(entry_code(TABLE_ENTRIES - 2)));
		corner_words.push_back(24'(entry_code(TABLE_ENTRIES - 2) + 1));
		corner_words.push_back(24'(entry_code(10)));
		corner_words.push_back(24'(entry_code(10) + 1));
		corner_words.push_back(24'h800000 | 24'(entry_code(5)));
		corner_words.push_back(24'(entry_code(5) + 1));
		corner_words.push_back(24'h015555);
		corner_words.push_back(24'h00AAAA);
		corner_words.push_back(24'h5A5A5A);
		corner_words.push_back(24'hA5A5A5);

		foreach (corner_words[i]) begin
			send_sample(corner_words[i]);
			maybe_idle();
		end

		// Let the pipeline empty completely before the random part starts.
		wait_for_drain();

		for (int n = 0; n < RANDOM_SAMPLES; n++) begin
			if (n == 150)
				calm <= 1'b1;
			else if (n == 230)
				calm <= 1'b0;
			send_sample(random_word());
			maybe_idle();
		end

		wait_for_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (failures == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/svt_pkg.sv
rtl/svt_ifs.sv
rtl/sensor_voltage_to_temperature.sv
verif/svt_reading_checker.sv
verif/sensor_voltage_to_temperature_test.sv
